// ----- src/tsdr_pkg.sv -----
// ----------------------------------------------------------------------------
// tsdr_pkg
// Shared types and constants of the tachometer speed and duty regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsdr_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TARGET_RPM   = 2'd0,
    REG_WINDOW_TICKS = 2'd1,
    REG_KICK_DUTY    = 2'd2,
    REG_MAX_STEP     = 2'd3
  } cfg_index_e;

  localparam int unsigned RPM_W  = 16;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned BYTE_W = 8;

  // Register reset values.
  localparam logic [RPM_W-1:0]  TARGET_RST = 16'd0;
  localparam logic [TICK_W-1:0] WINDOW_RST = 16'd1000;
  localparam logic [BYTE_W-1:0] KICK_RST   = 8'd150;
  localparam logic [BYTE_W-1:0] STEP_RST   = 8'd10;

  // Measurement constants. The pulse count saturates at 1092 pulses, so the
  // speed accumulator saturates at 1092 * 60 rpm.
  localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;
  localparam logic [RPM_W-1:0]  RPM_STEP   = 16'd60;
  localparam logic [RPM_W-1:0]  SPEED_SAT  = 16'd65520;

  // Regulation constants. Errors inside the band step by err / 10, which is
  // done as (err * 205) >> 11, exact for err up to 150.
  localparam logic [RPM_W-1:0]  ERR_BAND   = 16'd150;
  localparam logic [BYTE_W-1:0] DIV10_MUL  = 8'd205;
  localparam int unsigned       DIV10_SHIFT = 11;

  // Window close event from the measurement side.
  typedef struct packed {
    logic             closed;
    logic [RPM_W-1:0] speed;
  } window_event_t;

endpackage

`default_nettype wire

// ----- src/tach_speed_duty_regulator.sv -----
// ----------------------------------------------------------------------------
// tach_speed_duty_regulator
// Stirrer speed regulator driven by one tachometer sample per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one clock sample of the tachometer line and a
// millisecond tick flag. Every input beat produces exactly one result beat
// with the drive duty, the last measured speed and an update flag.
// Throughput is one beat per cycle while in_stall is low: the window
// counters and the duty regulator update in the cycle a beat is accepted,
// and the result is registered in the output register or the skid entry.
// The output register is backed by one skid entry, so a beat is still taken
// while a result waits under out_stall. in_stall rises only when both the
// output register and the skid entry are full, and drops again as soon as
// the receiver takes a beat.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata and must only change while no beats are in flight.
// Synchronous reset clears the window, the duty, the speed and the phase,
// empties the output buffer and loads the register defaults (target 0,
// window 1000 ticks, kick duty 150, step limit 10).
// ----------------------------------------------------------------------------
`default_nettype none

module tach_speed_duty_regulator
  import tsdr_pkg::*;
#(
  parameter int unsigned PWM_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input channel.
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_tach_high,
  input  wire logic                in_ms_tick,
  // Result channel.
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [PWM_BITS-1:0]      out_drive_duty,
  output logic [RPM_W-1:0]         out_speed_rpm,
  output logic                     out_updated,
  // Configuration port.
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [RPM_W-1:0]    cfg_wdata
);

  localparam int unsigned DW = PWM_BITS + RPM_W + 1;

  logic [RPM_W-1:0]    target_rpm_r;
  logic [TICK_W-1:0]   window_ticks_r;
  logic [BYTE_W-1:0]   kick_duty_r;
  logic [BYTE_W-1:0]   max_step_r;

  logic                accept;
  logic                motor_off;
  logic                buf_full;
  window_event_t       win_event;
  logic [PWM_BITS-1:0] res_duty;
  logic [RPM_W-1:0]    res_speed;
  logic                res_updated;
  logic [DW-1:0]       out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_rpm_r   <= TARGET_RST;
      window_ticks_r <= WINDOW_RST;
      kick_duty_r    <= KICK_RST;
      max_step_r     <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index_e'(cfg_index))
        REG_TARGET_RPM:   target_rpm_r   <= cfg_wdata;
        REG_WINDOW_TICKS: window_ticks_r <= cfg_wdata;
        REG_KICK_DUTY:    kick_duty_r    <= cfg_wdata[BYTE_W-1:0];
        REG_MAX_STEP:     max_step_r     <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = buf_full;
  assign accept    = in_valid && !in_stall;
  assign motor_off = (target_rpm_r == '0);

  // Pulse and tick counting over the measuring window.
  tsdr_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .clear        (motor_off),
    .tach_high    (in_tach_high),
    .ms_tick      (in_ms_tick),
    .window_ticks (window_ticks_r),
    .event_o      (win_event)
  );

  // Stall kick and duty regulation.
  tsdr_regulate #(
    .PWM_BITS (PWM_BITS)
  ) u_regulate (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .motor_off  (motor_off),
    .target_rpm (target_rpm_r),
    .kick_duty  (kick_duty_r),
    .max_step   (max_step_r),
    .event_i    (win_event),
    .drive_duty (res_duty),
    .speed_rpm  (res_speed),
    .updated    (res_updated)
  );

  // Result buffer toward the receiver.
  tsdr_out_buf #(
    .DW (DW)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data ({res_duty, res_speed, res_updated}),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_drive_duty = out_data[DW-1:RPM_W+1];
  assign out_speed_rpm  = out_data[RPM_W:1];
  assign out_updated    = out_data[0];

  // A full skid entry always sits behind a valid output register.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while the output register is empty");

  // The skid entry only fills when a beat arrives against a stalled output.
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(accept && out_valid && out_stall))
    else $error("skid entry filled without a stalled output");

  // A zero target never produces a result with nonzero duty or speed.
  a_motor_off_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && motor_off) |-> (res_duty == '0 && res_speed == '0 && !res_updated))
    else $error("nonzero result while the target is zero");

endmodule

`default_nettype wire

// ----- src/tsdr_window.sv -----
// ----------------------------------------------------------------------------
// tsdr_window
// Pulse counting and tick timing over one measuring window.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdr_window
  import tsdr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              clear,
  input  wire logic              tach_high,
  input  wire logic              ms_tick,
  input  wire logic [TICK_W-1:0] window_ticks,
  output window_event_t          event_o
);

  logic              level_r, level_nxt;
  logic [TICK_W-1:0] timer_r, timer_nxt;
  logic [RPM_W-1:0]  speed_acc_r, speed_acc_nxt;

  logic              rise;
  logic [RPM_W-1:0]  speed_inc;
  logic [TICK_W-1:0] timer_inc;
  logic              closed;

  // A rise counts 60 rpm into the accumulator until it saturates.
  always_comb begin
    rise      = tach_high && !level_r;
    speed_inc = (rise && (speed_acc_r != SPEED_SAT)) ? speed_acc_r + RPM_STEP
                                                     : speed_acc_r;
  end

  // The tick timer saturates and closes the window once it reaches the length.
  always_comb begin
    timer_inc = timer_r;
    if (ms_tick && (timer_r != TICK_MAX)) begin
      timer_inc = timer_r + 16'd1;
    end
    closed = ms_tick && (timer_inc >= window_ticks);
  end

  // Next window state: cleared when the window closes or while the motor is off.
  always_comb begin
    if (clear || closed) begin
      level_nxt     = 1'b0;
      timer_nxt     = '0;
      speed_acc_nxt = '0;
    end else begin
      level_nxt     = tach_high;
      timer_nxt     = timer_inc;
      speed_acc_nxt = speed_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= 1'b0;
      timer_r     <= '0;
      speed_acc_r <= '0;
    end else if (accept) begin
      level_r     <= level_nxt;
      timer_r     <= timer_nxt;
      speed_acc_r <= speed_acc_nxt;
    end
  end

  assign event_o.closed = closed && !clear;
  assign event_o.speed  = speed_inc;

endmodule

`default_nettype wire

// ----- src/tsdr_regulate.sv -----
// ----------------------------------------------------------------------------
// tsdr_regulate
// Stall kick and duty stepping at the close of each window.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdr_regulate
  import tsdr_pkg::*;
#(
  parameter int unsigned PWM_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                motor_off,
  input  wire logic [RPM_W-1:0]    target_rpm,
  input  wire logic [BYTE_W-1:0]   kick_duty,
  input  wire logic [BYTE_W-1:0]   max_step,
  input  window_event_t            event_i,
  output logic [PWM_BITS-1:0]      drive_duty,
  output logic [RPM_W-1:0]         speed_rpm,
  output logic                     updated
);

  localparam int unsigned SW = ((PWM_BITS > BYTE_W) ? PWM_BITS : BYTE_W) + 1;
  localparam logic [SW-1:0] DUTY_MAX_W = {{(SW-PWM_BITS){1'b0}}, {PWM_BITS{1'b1}}};
  localparam logic [PWM_BITS-1:0] DUTY_MAX = {PWM_BITS{1'b1}};
  localparam logic [PWM_BITS-1:0] KICK_FLASH = {{(PWM_BITS-1){1'b1}}, 1'b0};

  logic [PWM_BITS-1:0] duty_r, duty_nxt;
  logic [RPM_W-1:0]    speed_r, speed_nxt;
  logic                phase_r, phase_nxt;

  logic                below;
  logic [RPM_W-1:0]    err;
  logic [2*BYTE_W-1:0] div_prod;
  logic [BYTE_W-1:0]   step;
  logic [SW-1:0]       duty_w, step_w, sum_w, kick_w;
  logic [PWM_BITS-1:0] duty_reg;
  logic [PWM_BITS-1:0] kick_lim;
  logic                kicked;

  // Error against the freshly measured speed and the step it calls for.
  always_comb begin
    below    = event_i.speed < target_rpm;
    err      = below ? (target_rpm - event_i.speed) : (event_i.speed - target_rpm);
    div_prod = err[BYTE_W-1:0] * DIV10_MUL;
    step     = (err > ERR_BAND) ? max_step
                                : {{(BYTE_W-(2*BYTE_W-DIV10_SHIFT)){1'b0}},
                                   div_prod[2*BYTE_W-1:DIV10_SHIFT]};
  end

  // Step the duty up or down, clamped to the PWM range.
  always_comb begin
    duty_w = {{(SW-PWM_BITS){1'b0}}, duty_r};
    step_w = {{(SW-BYTE_W){1'b0}}, step};
    sum_w  = duty_w + step_w;
    if (below) begin
      duty_reg = (sum_w > DUTY_MAX_W) ? DUTY_MAX : sum_w[PWM_BITS-1:0];
    end else begin
      duty_reg = (step_w > duty_w) ? '0 : duty_r - step_w[PWM_BITS-1:0];
    end
    kick_w   = {{(SW-BYTE_W){1'b0}}, kick_duty};
    kick_lim = (kick_w > DUTY_MAX_W) ? DUTY_MAX : kick_w[PWM_BITS-1:0];
  end

  // State update and the result of this item.
  always_comb begin
    duty_nxt   = duty_r;
    speed_nxt  = speed_r;
    phase_nxt  = phase_r;
    kicked     = 1'b0;
    updated    = 1'b0;
    if (motor_off) begin
      duty_nxt  = '0;
      speed_nxt = '0;
      phase_nxt = 1'b0;
    end else if (event_i.closed) begin
      speed_nxt = event_i.speed;
      if (!phase_r && (event_i.speed == '0)) begin
        duty_nxt  = kick_lim;
        phase_nxt = 1'b1;
        kicked    = 1'b1;
      end else begin
        duty_nxt  = duty_reg;
        phase_nxt = 1'b0;
        updated   = 1'b1;
      end
    end
    drive_duty = kicked ? KICK_FLASH : duty_nxt;
    speed_rpm  = speed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r  <= '0;
      speed_r <= '0;
      phase_r <= 1'b0;
    end else if (accept) begin
      duty_r  <= duty_nxt;
      speed_r <= speed_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/tsdr_out_buf.sv -----
// ----------------------------------------------------------------------------
// tsdr_out_buf
// Output register with one skid entry between the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdr_out_buf #(
  parameter int unsigned DW = 25
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [DW-1:0]      out_data
);

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  logic [DW-1:0] skid_data_r, skid_data_nxt;
  logic          pop;

  // Fill the output register from the skid entry or the input, or park the input in the skid.
  always_comb begin
    pop            = out_valid_r && !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- dv/tsdr_checker.sv -----
// ----------------------------------------------------------------------------
// tsdr_checker
// Result checker for the tachometer speed and duty regulator.
// ----------------------------------------------------------------------------
// Watches the sample channel, the result channel and the configuration port.
// Every accepted sample beat is run through a behavioral copy of the window
// counter and the duty regulator. The expected result is queued, and each
// accepted result beat is compared field by field with the oldest entry.
// A result with nothing queued, a wrong field, and entries still queued when
// the run is declared done are all counted as failures.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdr_checker
  import tsdr_pkg::*;
#(
  parameter int unsigned PWM_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic                in_tach_high,
  input  wire logic                in_ms_tick,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [PWM_BITS-1:0] out_drive_duty,
  input  wire logic [RPM_W-1:0]    out_speed_rpm,
  input  wire logic                out_updated,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [RPM_W-1:0]    cfg_wdata,
  input  wire logic                run_done,
  output int unsigned              fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DUTY_TOP     = (1 << PWM_BITS) - 1;
  localparam int unsigned KICK_SHOW    = DUTY_TOP - 1;
  localparam int unsigned RPM_PER_RISE = 60;
  localparam int unsigned RISE_LIMIT   = 1092;
  localparam int unsigned ERR_LIMIT    = 150;
  localparam int unsigned ERR_DIV      = 10;
  localparam int unsigned MAX_PRINTED  = 100;

  typedef struct packed {
    logic [PWM_BITS-1:0] duty;
    logic [RPM_W-1:0]    speed;
    logic                updated;
  } regulator_result_t;

  regulator_result_t expected_q[$];

  // Register copies.
  logic [RPM_W-1:0]    want_rpm;
  logic [TICK_W-1:0]   window_len;
  logic [BYTE_W-1:0]   kick_level;
  logic [BYTE_W-1:0]   step_limit;

  // Measurement and regulation state.
  logic                level_prev;
  logic [TICK_W-1:0]   ticks_seen;
  logic [10:0]         rises;
  logic [RPM_W-1:0]    speed_meas;
  logic [PWM_BITS-1:0] duty_level;
  logic                remeasuring;

  int unsigned         result_idx;
  bit                  leftover_checked;

  initial fail_count = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < MAX_PRINTED)
      $display("%0t ns: result beat %0d, %s: got %0d, expected %0d",
               $time, result_idx, what, got, want);
    fail_count++;
  endtask

  task automatic clear_window();
    level_prev = 1'b0;
    ticks_seen = '0;
    rises      = '0;
  endtask

  // Advance the regulator by one sample beat and queue what it should show.
  task automatic step_regulator(input logic tach, input logic tick);
    regulator_result_t r;
    int unsigned       prod;
    int unsigned       err;
    int unsigned       step_sz;
    int unsigned       sum;
    logic              kicked;
    r      = '0;
    kicked = 1'b0;
    if (want_rpm == 0) begin
      // A zero target holds everything cleared and shows all zeros.
      duty_level  = '0;
      speed_meas  = '0;
      remeasuring = 1'b0;
      clear_window();
    end else begin
      // The sample is counted before the tick is looked at.
      if (tach && !level_prev && rises < RISE_LIMIT) rises++;
      level_prev = tach;
      if (tick) begin
        if (ticks_seen != TICK_MAX) ticks_seen++;
        if (ticks_seen >= window_len) begin
          prod       = rises * RPM_PER_RISE;
          speed_meas = (prod > 32'hFFFF) ? 16'hFFFF : RPM_W'(prod);
          clear_window();
          if (!remeasuring && speed_meas == 0) begin
            // Stalled motor: kick it and measure once more.
            duty_level  = (kick_level > DUTY_TOP) ? PWM_BITS'(DUTY_TOP)
                                                  : PWM_BITS'(kick_level);
            remeasuring = 1'b1;
            kicked      = 1'b1;
          end else begin
            err     = (speed_meas < want_rpm) ? want_rpm - speed_meas
                                              : speed_meas - want_rpm;
            step_sz = (err > ERR_LIMIT) ? step_limit : err / ERR_DIV;
            if (speed_meas < want_rpm) begin
              sum        = duty_level + step_sz;
              duty_level = (sum > DUTY_TOP) ? PWM_BITS'(DUTY_TOP) : PWM_BITS'(sum);
            end else begin
              duty_level = (step_sz > duty_level) ? '0
                                                  : PWM_BITS'(duty_level - step_sz);
            end
            remeasuring = 1'b0;
            r.updated   = 1'b1;
          end
        end
      end
      r.duty  = kicked ? PWM_BITS'(KICK_SHOW) : duty_level;
      r.speed = speed_meas;
    end
    expected_q.push_back(r);
  endtask

  // Results are compared before the beat of the same edge is predicted,
  // since a result always belongs to an earlier sample.
  always @(posedge clk) begin
    regulator_result_t want;
    if (!rst_n) begin
      want_rpm    = TARGET_RST;
      window_len  = WINDOW_RST;
      kick_level  = KICK_RST;
      step_limit  = STEP_RST;
      clear_window();
      speed_meas  = '0;
      duty_level  = '0;
      remeasuring = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no sample waiting", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_drive_duty !== want.duty)
            report_mismatch("drive_duty", out_drive_duty, want.duty);
          if (out_speed_rpm !== want.speed)
            report_mismatch("speed_rpm", out_speed_rpm, want.speed);
          if (out_updated !== want.updated)
            report_mismatch("updated", out_updated, want.updated);
        end
        result_idx++;
      end
      if (in_valid && !in_stall) step_regulator(in_tach_high, in_ms_tick);
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_RPM:   want_rpm   = cfg_wdata;
          REG_WINDOW_TICKS: window_len = cfg_wdata;
          REG_KICK_DUTY:    kick_level = cfg_wdata[BYTE_W-1:0];
          REG_MAX_STEP:     step_limit = cfg_wdata[BYTE_W-1:0];
          default: ;
        endcase
      end
      // Anything still queued at the end never came out.
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_q.size() != 0)
          report_mismatch("results never delivered", 0, expected_q.size());
      end
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_tach_speed_duty_regulator.sv -----
// ----------------------------------------------------------------------------
// tb_tach_speed_duty_regulator
// Testbench top for the tachometer speed and duty regulator.
// ----------------------------------------------------------------------------
// Drives tachometer sample beats with random gaps and a receiver with random
// stalls, including long hold-offs that back the block up into its input.
// A short directed run covers the zero target, a stall with its kick and
// remeasure, both duty clamps, the error band edge, a zero-length window and
// a window shortened below the running timer. Random phases with fresh
// register settings follow, and a burst of back to back pulses over an open
// window ends the run. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tach_speed_duty_regulator;

  import tsdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PWM_BITS        = 8;
  localparam int unsigned MAX_GAP         = 17;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned BEATS_PER_PHASE = 120;
  localparam int unsigned BURST_BEATS     = 60;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_tach_high;
  logic                in_ms_tick;
  logic                out_valid;
  logic                out_stall;
  logic [PWM_BITS-1:0] out_drive_duty;
  logic [RPM_W-1:0]    out_speed_rpm;
  logic                out_updated;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [RPM_W-1:0]    cfg_wdata;
  logic                run_done;
  int unsigned         fail_count;

  int unsigned         n_sent;
  int unsigned         n_got;
  int unsigned         quiet_cycles;
  bit                  idle_on;

  tach_speed_duty_regulator #(
    .PWM_BITS(PWM_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_tach_high  (in_tach_high),
    .in_ms_tick    (in_ms_tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_duty(out_drive_duty),
    .out_speed_rpm (out_speed_rpm),
    .out_updated   (out_updated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  tsdr_checker #(
    .PWM_BITS(PWM_BITS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_tach_high  (in_tach_high),
    .in_ms_tick    (in_ms_tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_duty(out_drive_duty),
    .out_speed_rpm (out_speed_rpm),
    .out_updated   (out_updated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .run_done      (run_done),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one sample beat after a random gap and wait until it is taken.
  task automatic send_sample(input logic tach, input logic tick);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_tach_high <= tach;
    in_ms_tick   <= tick;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Stop offering beats and wait until every result has been taken.
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_got != n_sent);
  endtask

  // Write all four registers on consecutive edges; only called while idle.
  task automatic load_settings(input logic [RPM_W-1:0] target,
                               input logic [TICK_W-1:0] window_len,
                               input logic [BYTE_W-1:0] kick,
                               input logic [BYTE_W-1:0] step_limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TARGET_RPM;
    cfg_wdata <= target;
    @(posedge clk);
    cfg_index <= REG_WINDOW_TICKS;
    cfg_wdata <= window_len;
    @(posedge clk);
    cfg_index <= REG_KICK_DUTY;
    cfg_wdata <= {8'd0, kick};
    @(posedge clk);
    cfg_index <= REG_MAX_STEP;
    cfg_wdata <= {8'd0, step_limit};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [RPM_W-1:0]  target;
    logic [TICK_W-1:0] window_len;
    logic [BYTE_W-1:0] kick;
    logic [BYTE_W-1:0] step_limit;
    int unsigned       tick_odds;
    int unsigned       toggle_odds;
    logic              tach_level;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_tach_high <= 1'b0;
    in_ms_tick   <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_TARGET_RPM;
    cfg_wdata    <= '0;
    run_done     <= 1'b0;
    idle_on       = 1'b1;
    n_sent        = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the target is zero, so everything reads as zero.
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    finish_phase();

    // Full target, one-tick windows: a pulse already high at window open
    // counts, the duty clamps high, then a stall kicks and remeasures.
    load_settings(16'hFFFF, 16'd1, 8'hFF, 8'hFF);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b1);
    finish_phase();

    // Tiny target, no kick duty, no step: the duty clamps at zero.
    load_settings(16'd1, 16'd1, 8'd0, 8'd0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    finish_phase();

    // Zero-length window, with the error right on the band edge.
    load_settings(16'd210, 16'd0, 8'd150, 8'd10);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    finish_phase();

    // Window shortened below the running timer closes on the next tick.
    load_settings(16'd211, 16'd3, 8'd150, 8'd10);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    finish_phase();
    load_settings(16'd211, 16'd1, 8'd150, 8'd10);
    send_sample(1'b1, 1'b1);
    finish_phase();

    // Random phases, each with its own settings and pulse rate.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase % 4) != 2;
      case ($urandom_range(0, 7))
        0:       target = '0;
        1:       target = 16'hFFFF;
        2:       target = RPM_W'($urandom_range(140, 220));
        3:       target = RPM_W'($urandom);
        default: target = RPM_W'($urandom_range(1, 1200));
      endcase
      case ($urandom_range(0, 9))
        0:       window_len = '0;
        1:       window_len = 16'hFFFF;
        2:       window_len = TICK_W'($urandom_range(20, 60));
        default: window_len = TICK_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       kick = 8'd0;
        1:       kick = 8'hFF;
        default: kick = BYTE_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       step_limit = 8'd0;
        1:       step_limit = 8'hFF;
        default: step_limit = BYTE_W'($urandom_range(1, 40));
      endcase
      tick_odds   = $urandom_range(1, 6);
      toggle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      tach_level  = 1'($urandom_range(0, 1));
      load_settings(target, window_len, kick, step_limit);
      repeat (BEATS_PER_PHASE) begin
        if ($urandom_range(1, 8) <= toggle_odds) tach_level = ~tach_level;
        send_sample(tach_level, $urandom_range(1, 8) <= tick_odds);
      end
      finish_phase();
    end

    // Back to back pulses with no tick, then ticks close the window.
    idle_on = 1'b0;
    load_settings(16'hFFFF, 16'd1, 8'd150, 8'd20);
    for (int i = 0; i < BURST_BEATS; i++) send_sample(i % 2 == 0, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b1);
    finish_phase();

    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls per beat, and two long hold-offs that fill
  // the block up while the sample side keeps offering beats.
  initial begin : result_sink
    int unsigned wait_cycles;
    n_got = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n_got == 500 || n_got == 1200) wait_cycles = LONG_HOLD;
      else wait_cycles = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      n_got++;
    end
  end

  // Watchdog: too long without any beat moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
